### sv/uri_pd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the URI percent decoder.
// Used by uri_pd_decode, uri_pd_serial and uri_percent_decoder.
package uri_pd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_CODE = 8'hf0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_CODE = 8'he0;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_CODE = 8'hc0;
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam int         SEQ_DEPTH  = 3;
    localparam int         MAX_OUT    = 4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HEX1  = 3'd1,
        PH_HEX2  = 3'd2,
        PH_CPCT  = 3'd3,
        PH_CHEX1 = 3'd4,
        PH_CHEX2 = 3'd5
    } phase_t;

    // results of one accepted item, held until drained
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [1:0]              last_idx;
        logic                    err;
        logic                    fin;
    } burst_t;

    // bit 4 set marks a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]})
        begin
            d = c - 8'h30;
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d = c - 8'h57;
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = c - 8'h37;
        end
        else
        begin
            d = 8'h10;
        end
        return d[4:0];
    endfunction

    function automatic logic is_reserved(input logic [7:0] b);
        return b inside {8'h3b, 8'h2f, 8'h3f, 8'h3a, 8'h40, 8'h26,
                         8'h3d, 8'h2b, 8'h24, 8'h2c, 8'h23};
    endfunction

    function automatic logic [1:0] lead_count(input logic [7:0] v);
        logic [1:0] n;
        if ((v & LEAD4_MASK) == LEAD4_CODE)
        begin
            n = 2'd3;
        end
        else if ((v & LEAD3_MASK) == LEAD3_CODE)
        begin
            n = 2'd2;
        end
        else if ((v & LEAD2_MASK) == LEAD2_CODE)
        begin
            n = 2'd1;
        end
        else
        begin
            n = 2'd0;
        end
        return n;
    endfunction

endpackage

### sv/uri_pd_decode.sv
`timescale 1ns / 1ps
// Escape parser: string state registers and the per-item result logic.
// Depends on uri_pd_pkg.
module uri_pd_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 string_end,
    output logic                 burst_load,
    output uri_pd_pkg::burst_t   burst
);

    uri_pd_pkg::phase_t phase_reg, phase_next;
    logic [7:0] fhc_reg, fhc_next;
    logic [1:0] cl_reg, cl_next;
    logic [1:0] bc_reg, bc_next;
    logic       err_reg, err_next;
    logic       mode_reg;
    logic [7:0] seq_mem [uri_pd_pkg::SEQ_DEPTH];
    logic       seq_we;
    logic [1:0] seq_idx;
    logic [7:0] seq_wdata;
    logic [4:0] h_in;
    logic [4:0] h_first;
    logic [7:0] v;
    logic [1:0] lead_n;

    assign h_in    = uri_pd_pkg::hex_value(in_byte);
    assign h_first = uri_pd_pkg::hex_value(fhc_reg);
    assign v       = {h_first[3:0], h_in[3:0]};
    assign lead_n  = uri_pd_pkg::lead_count(v);

    always_comb
    begin
        logic       bad;
        logic [2:0] n;
        phase_next = phase_reg;
        fhc_next   = fhc_reg;
        cl_next    = cl_reg;
        bc_next    = bc_reg;
        err_next   = err_reg;
        seq_we     = 1'b0;
        seq_idx    = bc_reg;
        seq_wdata  = v;
        bad        = 1'b0;
        n          = 3'd0;
        burst      = '0;
        if (err_reg)
        begin
            bad = string_end;
        end
        else
        begin
            case (phase_reg)
                uri_pd_pkg::PH_HEX1, uri_pd_pkg::PH_CHEX1:
                begin
                    if (h_in[4])
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        fhc_next   = in_byte;
                        phase_next = (phase_reg == uri_pd_pkg::PH_HEX1) ?
                                     uri_pd_pkg::PH_HEX2 : uri_pd_pkg::PH_CHEX2;
                    end
                end
                uri_pd_pkg::PH_HEX2:
                begin
                    if (h_in[4])
                    begin
                        bad = 1'b1;
                    end
                    else if (!v[7])
                    begin
                        if (mode_reg && uri_pd_pkg::is_reserved(v))
                        begin
                            burst.bytes[0] = uri_pd_pkg::PCT_CHAR;
                            burst.bytes[1] = fhc_reg;
                            burst.bytes[2] = in_byte;
                            n = 3'd3;
                        end
                        else
                        begin
                            burst.bytes[0] = v;
                            n = 3'd1;
                        end
                        phase_next = uri_pd_pkg::PH_IDLE;
                    end
                    else if (lead_n == 2'd0)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        seq_we     = 1'b1;
                        seq_idx    = 2'd0;
                        cl_next    = lead_n;
                        bc_next    = 2'd1;
                        phase_next = uri_pd_pkg::PH_CPCT;
                    end
                end
                uri_pd_pkg::PH_CPCT:
                begin
                    if (in_byte != uri_pd_pkg::PCT_CHAR)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        phase_next = uri_pd_pkg::PH_CHEX1;
                    end
                end
                uri_pd_pkg::PH_CHEX2:
                begin
                    if (h_in[4] || ((v & uri_pd_pkg::CONT_MASK) != uri_pd_pkg::CONT_CODE))
                    begin
                        bad = 1'b1;
                    end
                    else if (cl_reg <= 2'd1 || bc_reg == 2'd3)
                    begin
                        for (int i = 0; i < uri_pd_pkg::SEQ_DEPTH; i++)
                        begin
                            if (2'(i) < bc_reg)
                            begin
                                burst.bytes[i] = seq_mem[i];
                            end
                        end
                        burst.bytes[bc_reg] = v;
                        n          = {1'b0, bc_reg} + 3'd1;
                        cl_next    = 2'd0;
                        bc_next    = 2'd0;
                        phase_next = uri_pd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        seq_we     = 1'b1;
                        bc_next    = bc_reg + 2'd1;
                        cl_next    = cl_reg - 2'd1;
                        phase_next = uri_pd_pkg::PH_CPCT;
                    end
                end
                default:
                begin
                    if (in_byte != uri_pd_pkg::PCT_CHAR)
                    begin
                        burst.bytes[0] = in_byte;
                        n = 3'd1;
                    end
                    else
                    begin
                        phase_next = uri_pd_pkg::PH_HEX1;
                    end
                end
            endcase
            if (string_end && phase_next != uri_pd_pkg::PH_IDLE)
            begin
                bad = 1'b1;
            end
        end

        if (bad && !string_end)
        begin
            err_next   = 1'b1;
            phase_next = uri_pd_pkg::PH_IDLE;
            n          = 3'd0;
        end
        else if (bad)
        begin
            burst.bytes = '0;
            burst.err   = 1'b1;
            n           = 3'd1;
        end

        if (string_end)
        begin
            phase_next = uri_pd_pkg::PH_IDLE;
            fhc_next   = 8'h00;
            cl_next    = 2'd0;
            bc_next    = 2'd0;
            err_next   = 1'b0;
        end

        burst.fin      = string_end;
        burst.last_idx = 2'(n - 3'd1);
        burst_load     = accept && (n != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uri_pd_pkg::PH_IDLE;
            fhc_reg   <= 8'h00;
            cl_reg    <= 2'd0;
            bc_reg    <= 2'd0;
            err_reg   <= 1'b0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                fhc_reg   <= fhc_next;
                cl_reg    <= cl_next;
                bc_reg    <= bc_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && seq_we)
        begin
            seq_mem[seq_idx] <= seq_wdata;
        end
    end

endmodule

### sv/uri_pd_serial.sv
`timescale 1ns / 1ps
// Result register: holds one item's results and hands them out one per cycle while out_ready is high.
// Depends on uri_pd_pkg.
module uri_pd_serial (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 burst_load,
    input  uri_pd_pkg::burst_t   burst,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 is_error,
    output logic                 run_last,
    output logic                 string_last
);

    uri_pd_pkg::burst_t burst_reg;
    logic               valid_reg, valid_next;
    logic [1:0]         idx_reg, idx_next;

    assign out_valid   = valid_reg;
    assign out_byte    = burst_reg.bytes[idx_reg];
    assign is_error    = burst_reg.err;
    assign run_last    = (idx_reg == burst_reg.last_idx);
    assign string_last = run_last && burst_reg.fin;
    assign free        = !valid_reg || (out_ready && run_last);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (burst_load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (valid_reg && out_ready)
        begin
            if (run_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_load)
        begin
            burst_reg <= burst;
        end
    end

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        burst_load |-> free)
        else $error("results loaded over undrained item");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> idx_reg <= burst_reg.last_idx)
        else $error("result index past end of item");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && is_error) |-> (out_byte == 8'h00 && run_last && string_last))
        else $error("error result malformed");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && run_last && !burst_load) |=> !valid_reg)
        else $error("result register not emptied after last result");

endmodule

### sv/uri_percent_decoder.sv
`timescale 1ns / 1ps
// URI percent decoder top level: parser and result register.
// Depends on uri_pd_pkg, uri_pd_decode and uri_pd_serial.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one string byte per item in
//   in_byte, with string_end set on the final byte. Output channel
//   (out_valid/out_ready) carries up to 4 results per item: out_byte, is_error,
//   run_last (last result of its input item) and string_last.
//   cfg_we/cfg_wdata write reserved_mode (1 keeps ;/?:@&=+$,# escaped).
// Timing:
//   An item is parsed in the cycle it is accepted; its first result is
//   valid on the next cycle. An item yields 0 to 4 results, drained one per
//   cycle while out_ready is high from the result register. A new item is
//   accepted in the same cycle as the last result of the previous one is
//   taken, giving one item per cycle for single-result bytes while
//   out_ready is high; an item with no result still waits while the
//   result register holds undrained results.
// Reset: clears parser state, the error latch, reserved_mode and the output valid flag.
// Stall: with out_ready low the result register holds and in_ready drops.
module uri_percent_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_error,
    output logic       run_last,
    output logic       string_last
);

    uri_pd_pkg::burst_t burst;
    logic               burst_load;
    logic               free;
    logic               accept;

    assign in_ready = free;
    assign accept   = in_valid && free;

    uri_pd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .in_byte    (in_byte),
        .string_end (string_end),
        .burst_load (burst_load),
        .burst      (burst)
    );

    uri_pd_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_load  (burst_load),
        .burst       (burst),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .is_error    (is_error),
        .run_last    (run_last),
        .string_last (string_last)
    );

endmodule
